// File: hw/rtl/cht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cht_pkg
// Shared widths, defaults and codes of the chained hash table core.
// ----------------------------------------------------------------------------
package cht_pkg;

    // Fixed field widths of the channels
    localparam int CMD_W   = 2;
    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;
    localparam int SEL_W   = 8;
    localparam int STAT_W  = 2;
    localparam int CFG_W   = 9;
    localparam int ENT_W   = 9;

    // Parameter defaults
    localparam int DEF_MAX_BUCKETS = 256;
    localparam int DEF_POOL_NODES  = 256;
    localparam int DEF_KEY_BITS    = 32;
    localparam int DEF_VALUE_BITS  = 32;

    // Bucket count after reset
    localparam logic [CFG_W-1:0] BUCKET_COUNT_RESET = CFG_W'(251);

    // Commands
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_LENGTH = 2'd3;

    // Result status
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS     = 2'd1;
    localparam logic [STAT_W-1:0] ST_POOLFULL = 2'd2;

endpackage
`default_nettype wire

// File: hw/rtl/cht_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cht_if
// Channel interfaces: request, response and bucket count write.
// ----------------------------------------------------------------------------
interface cht_req_if;
    logic                           valid;
    logic                           ready;
    logic [cht_pkg::CMD_W-1:0]      command;
    logic [cht_pkg::KEY_W-1:0]      key;
    logic [cht_pkg::VALUE_W-1:0]    value_in;
    logic [cht_pkg::SEL_W-1:0]      bucket_select;

    modport source (output valid, command, key, value_in, bucket_select, input ready);
    modport sink   (input valid, command, key, value_in, bucket_select, output ready);
endinterface

interface cht_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [cht_pkg::STAT_W-1:0]     status;
    logic [cht_pkg::VALUE_W-1:0]    value_out;
    logic [cht_pkg::ENT_W-1:0]      bucket_length;

    modport source (output valid, status, value_out, bucket_length, input ready);
    modport sink   (input valid, status, value_out, bucket_length, output ready);
endinterface

interface cht_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [cht_pkg::CFG_W-1:0]      data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/chained_hash_table_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chained_hash_table_core
// Hash table with separate chaining over a bounded node pool.
// ----------------------------------------------------------------------------
// After reset the core sweeps max(MAX_BUCKETS, POOL_NODES) memory addresses
// (256 by default) to null the bucket heads, zero the bucket counts
// and chain all nodes into the free list; no request is taken meanwhile,
// bucket count writes are. It then works on one request at a time. Insert,
// lookup and delete first reduce the key modulo the bucket count in a
// two-bit-per-cycle remainder unit, then read the bucket head. Lookup and
// delete read one chain node per cycle from the node memories; a match
// ends the walk, a delete then returns the node to the free list, and a
// miss walks the whole chain. A length query reads the bucket count
// directly. The core goes back to idle in the same cycle that its
// response shows; a finished response sits in an output register, so the
// next request is taken while it waits.
// ----------------------------------------------------------------------------
module chained_hash_table_core #(
    parameter int MAX_BUCKETS = cht_pkg::DEF_MAX_BUCKETS,
    parameter int POOL_NODES  = cht_pkg::DEF_POOL_NODES,
    parameter int KEY_BITS    = cht_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS  = cht_pkg::DEF_VALUE_BITS
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    cht_cfg_if.sink     cfg,
    cht_req_if.sink     req,
    cht_rsp_if.source   rsp
);

    localparam int CFG_W      = cht_pkg::CFG_W;
    localparam int ENT_W      = cht_pkg::ENT_W;
    localparam int BKT_W      = $clog2(MAX_BUCKETS);
    localparam int NA_W       = $clog2(POOL_NODES);
    localparam int PTR_W      = NA_W + 1;
    localparam int INIT_N     = (MAX_BUCKETS > POOL_NODES) ? MAX_BUCKETS : POOL_NODES;
    localparam int INIT_W     = $clog2(INIT_N);
    localparam int KEY_PAD    = KEY_BITS + (KEY_BITS % 2);
    localparam int HASH_STEPS = KEY_PAD / 2;
    localparam int HC_W       = $clog2(HASH_STEPS + 1);

    localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_NODES);

    // Sequencer states
    localparam logic [3:0] S_INIT = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_HASH = 4'd2;
    localparam logic [3:0] S_HEAD = 4'd3;
    localparam logic [3:0] S_INS  = 4'd4;
    localparam logic [3:0] S_CHK  = 4'd5;
    localparam logic [3:0] S_NODE = 4'd6;
    localparam logic [3:0] S_DEL  = 4'd7;
    localparam logic [3:0] S_LEN  = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    // Registers
    logic [3:0]                  state_reg, state_next;
    logic [INIT_W-1:0]           init_cnt_reg, init_cnt_next;
    logic [CFG_W-1:0]            cfg_reg;
    logic [cht_pkg::CMD_W-1:0]   cmd_reg, cmd_next;
    logic [KEY_BITS-1:0]         key_reg, key_next;
    logic [VALUE_BITS-1:0]       val_reg, val_next;
    logic [KEY_PAD-1:0]          sh_reg, sh_next;
    logic [HC_W-1:0]             hcnt_reg, hcnt_next;
    logic [CFG_W-1:0]            rem_reg, rem_next;
    logic [BKT_W-1:0]            bkt_reg, bkt_next;
    logic [PTR_W-1:0]            free_reg, free_next;
    logic [PTR_W-1:0]            cur_reg, cur_next;
    logic [PTR_W-1:0]            prev_reg, prev_next;
    logic [cht_pkg::STAT_W-1:0]  res_status_reg, res_status_next;
    logic [cht_pkg::VALUE_W-1:0] res_value_reg, res_value_next;
    logic [ENT_W-1:0]            res_len_reg, res_len_next;
    logic                        out_valid_reg, out_valid_next;
    logic [cht_pkg::STAT_W-1:0]  out_status_reg, out_status_next;
    logic [cht_pkg::VALUE_W-1:0] out_value_reg, out_value_next;
    logic [ENT_W-1:0]            out_len_reg, out_len_next;

    // Memory ports
    logic              head_we;
    logic [BKT_W-1:0]  head_waddr, head_raddr;
    logic [PTR_W-1:0]  head_wdata, head_rd;
    logic              ent_we;
    logic [BKT_W-1:0]  ent_waddr, ent_raddr;
    logic [ENT_W-1:0]  ent_wdata, ent_rd;
    logic              node_we;
    logic [NA_W-1:0]   node_waddr, node_raddr;
    logic [KEY_BITS-1:0]   key_rd;
    logic [VALUE_BITS-1:0] val_rd;
    logic              link_we;
    logic [NA_W-1:0]   link_waddr, link_raddr;
    logic [PTR_W-1:0]  link_wdata, link_rd;

    logic [CFG_W-1:0]  n_eff;
    logic [CFG_W-1:0]  rem_mid;

    // One restoring remainder step: shift in a key bit, subtract n if reached
    function automatic logic [CFG_W-1:0] mod_step(input logic [CFG_W-1:0] r,
                                                  input logic b,
                                                  input logic [CFG_W-1:0] n);
        logic [CFG_W:0] t;
        t = {r, b};
        if (t >= {1'b0, n})
        begin
            t = t - {1'b0, n};
        end
        return t[CFG_W-1:0];
    endfunction

    // Memories
    cht_ram #(.WIDTH(PTR_W), .DEPTH(MAX_BUCKETS)) u_head (
        .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .raddr(head_raddr), .rdata(head_rd)
    );

    cht_ram #(.WIDTH(ENT_W), .DEPTH(MAX_BUCKETS)) u_entries (
        .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
        .raddr(ent_raddr), .rdata(ent_rd)
    );

    cht_ram #(.WIDTH(KEY_BITS), .DEPTH(POOL_NODES)) u_node_key (
        .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(key_reg),
        .raddr(node_raddr), .rdata(key_rd)
    );

    cht_ram #(.WIDTH(VALUE_BITS), .DEPTH(POOL_NODES)) u_node_value (
        .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(val_reg),
        .raddr(node_raddr), .rdata(val_rd)
    );

    cht_ram #(.WIDTH(PTR_W), .DEPTH(POOL_NODES)) u_node_link (
        .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
        .raddr(link_raddr), .rdata(link_rd)
    );

    // Effective bucket count: zero acts as one, saturate at MAX_BUCKETS
    always_comb
    begin
        if (cfg_reg == '0)
        begin
            n_eff = CFG_W'(1);
        end
        else if (32'(cfg_reg) > 32'(MAX_BUCKETS))
        begin
            n_eff = CFG_W'(MAX_BUCKETS);
        end
        else
        begin
            n_eff = cfg_reg;
        end
    end

    assign rem_mid = mod_step(rem_reg, sh_reg[KEY_PAD-1], n_eff);

    // Bucket count register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= cht_pkg::BUCKET_COUNT_RESET;
        end
        else if (cfg.valid)
        begin
            cfg_reg <= cfg.data;
        end
    end

    assign req.ready     = (state_reg == S_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.value_out = out_value_reg;
    assign rsp.bucket_length = out_len_reg;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        init_cnt_next   = init_cnt_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        sh_next         = sh_reg;
        hcnt_next       = hcnt_reg;
        rem_next        = rem_reg;
        bkt_next        = bkt_reg;
        free_next       = free_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        res_len_next    = res_len_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_len_next    = out_len_reg;

        head_we    = 1'b0;
        head_waddr = bkt_reg;
        head_wdata = free_reg;
        head_raddr = bkt_reg;
        ent_we     = 1'b0;
        ent_waddr  = bkt_reg;
        ent_wdata  = ENT_W'(ent_rd + ENT_W'(1));
        ent_raddr  = bkt_reg;
        node_we    = 1'b0;
        node_waddr = free_reg[NA_W-1:0];
        node_raddr = cur_reg[NA_W-1:0];
        link_we    = 1'b0;
        link_waddr = free_reg[NA_W-1:0];
        link_wdata = head_rd;
        link_raddr = cur_reg[NA_W-1:0];

        case (state_reg)
            // Clearing sweep after reset
            S_INIT:
            begin
                if (32'(init_cnt_reg) < 32'(MAX_BUCKETS))
                begin
                    head_we    = 1'b1;
                    head_waddr = BKT_W'(init_cnt_reg);
                    head_wdata = NIL;
                    ent_we     = 1'b1;
                    ent_waddr  = BKT_W'(init_cnt_reg);
                    ent_wdata  = '0;
                end
                if (32'(init_cnt_reg) < 32'(POOL_NODES))
                begin
                    link_we    = 1'b1;
                    link_waddr = NA_W'(init_cnt_reg);
                    link_wdata = PTR_W'(32'(init_cnt_reg) + 1);
                end
                if (32'(init_cnt_reg) == INIT_N - 1)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    init_cnt_next = INIT_W'(32'(init_cnt_reg) + 1);
                end
            end

            S_IDLE:
            begin
                ent_raddr = BKT_W'(req.bucket_select);
                if (req.valid)
                begin
                    cmd_next        = req.command;
                    key_next        = KEY_BITS'(req.key);
                    val_next        = VALUE_BITS'(req.value_in);
                    sh_next         = KEY_PAD'(KEY_BITS'(req.key));
                    hcnt_next       = '0;
                    rem_next        = '0;
                    res_status_next = cht_pkg::ST_MISS;
                    res_value_next  = '0;
                    res_len_next    = '0;
                    if (req.command == cht_pkg::CMD_LENGTH)
                    begin
                        if ({1'b0, req.bucket_select} < n_eff)
                        begin
                            state_next = S_LEN;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        state_next = S_HASH;
                    end
                end
            end

            // Key modulo bucket count, two bits per cycle
            S_HASH:
            begin
                rem_next  = mod_step(rem_mid, sh_reg[KEY_PAD-2], n_eff);
                sh_next   = {sh_reg[KEY_PAD-3:0], 2'b00};
                hcnt_next = HC_W'(hcnt_reg + HC_W'(1));
                if (32'(hcnt_reg) == HASH_STEPS - 1)
                begin
                    bkt_next   = BKT_W'(mod_step(rem_mid, sh_reg[KEY_PAD-2], n_eff));
                    state_next = S_HEAD;
                end
            end

            // Head, count and free-list successor reads issued here
            S_HEAD:
            begin
                link_raddr = free_reg[NA_W-1:0];
                prev_next  = NIL;
                if (cmd_reg == cht_pkg::CMD_INSERT)
                begin
                    if (free_reg == NIL)
                    begin
                        res_status_next = cht_pkg::ST_POOLFULL;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_INS;
                    end
                end
                else
                begin
                    state_next = S_CHK;
                end
            end

            // Link the free head node in front of the bucket chain
            S_INS:
            begin
                node_we         = 1'b1;
                link_we         = 1'b1;
                link_wdata      = head_rd;
                head_we         = 1'b1;
                head_wdata      = free_reg;
                ent_we          = 1'b1;
                ent_wdata       = ENT_W'(ent_rd + ENT_W'(1));
                free_next       = link_rd;
                res_status_next = cht_pkg::ST_OK;
                state_next      = S_DONE;
            end

            // First chain node, read issued from the head data
            S_CHK:
            begin
                node_raddr = head_rd[NA_W-1:0];
                link_raddr = head_rd[NA_W-1:0];
                if (head_rd == NIL)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cur_next   = head_rd;
                    state_next = S_NODE;
                end
            end

            // Compare one node; on a miss the next read follows the link
            S_NODE:
            begin
                node_raddr = link_rd[NA_W-1:0];
                link_raddr = link_rd[NA_W-1:0];
                if (key_rd == key_reg)
                begin
                    res_status_next = cht_pkg::ST_OK;
                    res_value_next  = cht_pkg::VALUE_W'(val_rd);
                    if (cmd_reg == cht_pkg::CMD_DELETE)
                    begin
                        if (prev_reg == NIL)
                        begin
                            head_we    = 1'b1;
                            head_wdata = link_rd;
                        end
                        else
                        begin
                            link_we    = 1'b1;
                            link_waddr = prev_reg[NA_W-1:0];
                            link_wdata = link_rd;
                        end
                        ent_we     = 1'b1;
                        ent_wdata  = ENT_W'(ent_rd - ENT_W'(1));
                        state_next = S_DEL;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else if (link_rd == NIL)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    prev_next = cur_reg;
                    cur_next  = link_rd;
                end
            end

            // Return the removed node to the free list head
            S_DEL:
            begin
                link_we    = 1'b1;
                link_waddr = cur_reg[NA_W-1:0];
                link_wdata = free_reg;
                free_next  = cur_reg;
                state_next = S_DONE;
            end

            S_LEN:
            begin
                res_status_next = cht_pkg::ST_OK;
                res_len_next    = ent_rd;
                state_next      = S_DONE;
            end

            // Hand the response to the output register once it is free
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_value_next  = res_value_reg;
                    out_len_next    = res_len_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            init_cnt_reg  <= '0;
            free_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_cnt_reg  <= init_cnt_next;
            free_reg      <= free_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        sh_reg         <= sh_next;
        hcnt_reg       <= hcnt_next;
        rem_reg        <= rem_next;
        bkt_reg        <= bkt_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        res_len_reg    <= res_len_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_len_reg    <= out_len_next;
    end

    // Checks
    a_free_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= NIL)
        else $error("free list head beyond null marker");

    a_no_req_in_init: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_INIT |-> !req.ready)
        else $error("request taken during clearing sweep");

    a_bucket_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_HEAD |-> 32'(bkt_reg) < 32'(n_eff))
        else $error("bucket index not below bucket count");

    a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && !rsp.ready) |=> state_reg == S_DONE)
        else $error("response overwrote a pending beat");

endmodule
`default_nettype wire

// File: hw/rtl/cht_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cht_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: tb/sv/cht_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cht_checker
// Watches the request, response and bucket count channels of the chained
// hash table core, keeps its own copy of the table and compares every
// response beat with the expected one.
// ----------------------------------------------------------------------------
module cht_checker
    import cht_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    cht_cfg_if      cfg,
    cht_req_if      req,
    cht_rsp_if      rsp,
    output int      errors,
    output int      outstanding,
    output int      checked
);

    localparam int NBKT = DEF_MAX_BUCKETS;
    localparam int NPOOL = DEF_POOL_NODES;
    localparam logic [ENT_W-1:0] NULL_NODE = ENT_W'(NPOOL);

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [VALUE_W-1:0] value_out;
        logic [ENT_W-1:0]   bucket_length;
    } table_result_t;

    // Shadow copy of the table
    logic [CFG_W-1:0]   bucket_cfg;
    logic [ENT_W-1:0]   head_of[NBKT];
    logic [ENT_W-1:0]   len_of[NBKT];
    logic [KEY_W-1:0]   key_of[NPOOL];
    logic [VALUE_W-1:0] val_of[NPOOL];
    logic [ENT_W-1:0]   next_of[NPOOL];
    logic [ENT_W-1:0]   free_node;

    table_result_t      pending_results[$];

    function automatic int live_buckets();
        int n;
        n = bucket_cfg;
        if (n == 0) n = 1;
        if (n > NBKT) n = NBKT;
        return n;
    endfunction

    // Apply one command to the shadow table and return the expected response
    function automatic table_result_t apply_command(logic [CMD_W-1:0] cmd,
                                                    logic [KEY_W-1:0] k,
                                                    logic [VALUE_W-1:0] v,
                                                    logic [SEL_W-1:0] sel);
        table_result_t r;
        int b;
        int n;
        int prev;
        int steps;
        r = '{status: ST_MISS, value_out: '0, bucket_length: '0};
        b = k % live_buckets();
        case (cmd)
            CMD_INSERT:
            begin
                n = free_node;
                if (n >= NPOOL)
                    r.status = ST_POOLFULL;
                else
                begin
                    free_node = next_of[n];
                    key_of[n] = k;
                    val_of[n] = v;
                    next_of[n] = head_of[b];
                    head_of[b] = ENT_W'(n);
                    len_of[b] = len_of[b] + 1'b1;
                    r.status = ST_OK;
                end
            end
            CMD_LOOKUP, CMD_DELETE:
            begin
                prev = NPOOL;
                n = head_of[b];
                steps = 0;
                while (n < NPOOL && steps < NPOOL)
                begin
                    if (key_of[n] == k)
                    begin
                        r.status = ST_OK;
                        r.value_out = val_of[n];
                        if (cmd == CMD_DELETE)
                        begin
                            // unlink and push back on the free list
                            if (prev >= NPOOL) head_of[b] = next_of[n];
                            else next_of[prev] = next_of[n];
                            next_of[n] = free_node;
                            free_node = ENT_W'(n);
                            len_of[b] = len_of[b] - 1'b1;
                        end
                        break;
                    end
                    prev = n;
                    n = next_of[n];
                    steps++;
                end
            end
            default:
            begin
                if (sel < live_buckets())
                begin
                    r.status = ST_OK;
                    r.bucket_length = len_of[sel];
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        table_result_t want;
        if (!rst_n)
        begin
            bucket_cfg = BUCKET_COUNT_RESET;
            for (int i = 0; i < NBKT; i++)
            begin
                head_of[i] = NULL_NODE;
                len_of[i] = '0;
            end
            for (int i = 0; i < NPOOL; i++)
            begin
                key_of[i] = '0;
                val_of[i] = '0;
                next_of[i] = ENT_W'(i + 1);
            end
            free_node = '0;
            pending_results.delete();
            errors = 0;
            checked = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                bucket_cfg = cfg.data;
            if (req.valid && req.ready)
                pending_results.push_back(apply_command(req.command, req.key,
                                                        req.value_in, req.bucket_select));
            // response beat against the oldest expectation
            if (rsp.valid && rsp.ready)
            begin
                checked++;
                if (pending_results.size() == 0)
                begin
                    $error("response beat with no request outstanding");
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $error("status expected %0d actual %0d", want.status, rsp.status);
                        errors++;
                    end
                    if (rsp.value_out !== want.value_out)
                    begin
                        $error("value_out expected %0h actual %0h",
                               want.value_out, rsp.value_out);
                        errors++;
                    end
                    if (rsp.bucket_length !== want.bucket_length)
                    begin
                        $error("bucket_length expected %0d actual %0d",
                               want.bucket_length, rsp.bucket_length);
                        errors++;
                    end
                end
            end
        end
        outstanding = pending_results.size();
    end

endmodule

// File: tb/sv/tb_chained_hash_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chained_hash_table_core
// Drives directed and random insert, lookup, delete and length beats into
// the chained hash table core under several bucket counts, with random
// idling on both sides, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_chained_hash_table_core;
    import cht_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD = 400;

    logic clk;
    logic rst_n;
    int   errors;
    int   outstanding;
    int   checked;
    bit   idle_on;
    bit   long_hold;
    int   quiet_cycles;
    logic [KEY_W-1:0] key_set[16];

    cht_cfg_if cfg();
    cht_req_if req();
    cht_rsp_if rsp();

    chained_hash_table_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .rsp   (rsp)
    );

    cht_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .req         (req),
        .rsp         (rsp),
        .errors      (errors),
        .outstanding (outstanding),
        .checked     (checked)
    );

    always #1 clk = ~clk;

    // Watchdog: cycles with no beat on any channel
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_chained_hash_table_core: errors");
            $finish;
        end
    end

    // Response side: random ready bursts and one long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                rsp.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            else
            begin
                rsp.ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    task automatic wait_drained();
        do @(posedge clk); while (outstanding != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_buckets(logic [CFG_W-1:0] n);
        wait_drained();
        cfg.valid <= 1'b1;
        cfg.data <= n;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    // One request beat, with an optional random gap in front
    task automatic send(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] k,
                        logic [VALUE_W-1:0] v, logic [SEL_W-1:0] sel);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.command <= cmd;
        req.key <= k;
        req.value_in <= v;
        req.bucket_select <= sel;
        do @(posedge clk); while (!req.ready);
    endtask

    task automatic stop_sending();
        req.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Random mix over a small key set so chains grow and entries are hit
    task automatic random_phase(int count);
        logic [KEY_W-1:0] k;
        int pick;
        for (int i = 0; i < 16; i++)
            key_set[i] = (i < 8) ? KEY_W'(i * $urandom_range(1, 3)) : $urandom();
        for (int i = 0; i < count; i++)
        begin
            k = ($urandom_range(0, 3) == 0) ? $urandom() : key_set[$urandom_range(0, 15)];
            pick = $urandom_range(0, 99);
            if (pick < 35)
                send(CMD_INSERT, k, $urandom(), $urandom());
            else if (pick < 60)
                send(CMD_LOOKUP, k, $urandom(), $urandom());
            else if (pick < 85)
                send(CMD_DELETE, k, $urandom(), $urandom());
            else
                send(CMD_LENGTH, k, $urandom(), $urandom());
        end
        stop_sending();
    endtask

    initial
    begin
        logic [CFG_W-1:0] counts[8];
        clk = 1'b0;
        rst_n = 1'b0;
        idle_on = 1'b1;
        long_hold = 1'b0;
        quiet_cycles = 0;
        req.valid = 1'b0;
        req.command = CMD_INSERT;
        req.key = '0;
        req.value_in = '0;
        req.bucket_select = '0;
        rsp.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty table, extremes, duplicates, collisions
        send(CMD_LENGTH, '0, '0, 8'd0);
        send(CMD_LENGTH, '0, '0, 8'd250);
        send(CMD_LENGTH, '0, '0, 8'd251);
        send(CMD_LENGTH, '0, '0, 8'd255);
        send(CMD_LOOKUP, 32'd7, '0, '0);
        send(CMD_DELETE, 32'd7, '0, '0);
        send(CMD_INSERT, '0, '0, '0);
        send(CMD_INSERT, '1, '1, '1);
        send(CMD_INSERT, 32'd5, 32'h1111_1111, '0);
        send(CMD_INSERT, 32'd5, 32'h2222_2222, '0);
        send(CMD_LOOKUP, 32'd5, '0, '0);
        send(CMD_DELETE, 32'd5, '0, '0);
        send(CMD_LOOKUP, 32'd5, '0, '0);
        send(CMD_DELETE, 32'd5, '0, '0);
        send(CMD_DELETE, 32'd5, '0, '0);
        send(CMD_LOOKUP, '1, '0, '0);
        send(CMD_LENGTH, '0, '0, 8'(32'hFFFF_FFFF % 251));
        send(CMD_INSERT, 32'd251, 32'hA5A5_5A5A, '0);
        send(CMD_LENGTH, '0, '0, 8'd0);
        send(CMD_DELETE, '0, '0, '0);
        send(CMD_LOOKUP, 32'd251, '0, '0);
        stop_sending();

        // Pool exhaustion in one bucket while the response side stalls
        set_buckets(9'd1);
        long_hold = 1'b1;
        for (int i = 0; i < 260; i++)
            send(CMD_INSERT, $urandom_range(0, 63), $urandom(), '0);
        send(CMD_LOOKUP, 32'd1000, '0, '0);
        send(CMD_LENGTH, '0, '0, 8'd0);
        send(CMD_LENGTH, '0, '0, 8'd1);
        for (int i = 0; i < 260; i++)
            send(CMD_DELETE, $urandom_range(0, 63), '0, '0);
        stop_sending();
        wait_drained();

        // Random phases over bucket counts, extremes included
        counts = '{9'd0, 9'd2, 9'd256, 9'd511, 9'd300, 9'd7, 9'd128, 9'd251};
        foreach (counts[i])
        begin
            if (i == 6)
                idle_on = 1'b0;
            set_buckets(counts[i]);
            random_phase(60);
        end
        send(CMD_LENGTH, '0, '0, 8'd255);
        stop_sending();

        wait_drained();
        repeat (50) @(posedge clk);
        $display("Covered %0d responses: directed extremes, a full pool with a long stall,",
                 checked);
        $display("and random traffic over bucket counts 0 to 511.");
        if (errors == 0)
            $display("tb_chained_hash_table_core: clean");
        else
            $display("tb_chained_hash_table_core: errors");
        $finish;
    end

endmodule

// File: chained_hash_table_core.f
hw/rtl/cht_pkg.sv
hw/rtl/cht_if.sv
hw/rtl/cht_ram.sv
hw/rtl/chained_hash_table_core.sv
tb/sv/cht_checker.sv
tb/sv/tb_chained_hash_table_core.sv
